FILE: hw/rtl/register_alu_branch_unit_defines.svh
// Assertion macros for the checker file of the register ALU branch unit.
// Depends on nothing; files that assert include it by its bare name.
`ifndef REGISTER_ALU_BRANCH_UNIT_DEFINES_SVH
`define REGISTER_ALU_BRANCH_UNIT_DEFINES_SVH

// Concurrent assertion that is switched off while the reset is asserted.
`define RABU_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that also holds while the reset is asserted.
`define RABU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/rabu_pkg.sv
// Package of the register ALU branch unit: opcodes, field types and word structs.
// Depends on nothing; every RTL file of the unit but rabu_ram imports it.
`timescale 1ns / 1ps

package rabu_pkg;

  localparam int unsigned XLen     = 64;
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned NumPtrs  = 4;
  localparam int unsigned FlagZ    = 3;
  localparam int unsigned FlagN    = 2;
  localparam int unsigned FlagC    = 1;
  localparam int unsigned FlagV    = 0;
  localparam logic [RegIdxW-1:0] LinkReg = 3'd7;

  typedef enum logic [5:0] {
    OP_ADD2    = 6'd0,
    OP_ADD2I   = 6'd1,
    OP_SUB2    = 6'd2,
    OP_SUB2I   = 6'd3,
    OP_CMP     = 6'd4,
    OP_CMPI    = 6'd5,
    OP_LET     = 6'd6,
    OP_LETI    = 6'd7,
    OP_SHIFT   = 6'd8,
    OP_READZE  = 6'd9,
    OP_READSE  = 6'd10,
    OP_JUMP    = 6'd11,
    OP_JUMPIF  = 6'd12,
    OP_OR2     = 6'd13,
    OP_OR2I    = 6'd14,
    OP_AND2    = 6'd15,
    OP_AND2I   = 6'd16,
    OP_WRITE   = 6'd17,
    OP_CALL    = 6'd18,
    OP_SETCTR  = 6'd19,
    OP_GETCTR  = 6'd20,
    OP_PUSH    = 6'd21,
    OP_RETURN  = 6'd22,
    OP_ADD3    = 6'd23,
    OP_ADD3I   = 6'd24,
    OP_SUB3    = 6'd25,
    OP_SUB3I   = 6'd26,
    OP_AND3    = 6'd27,
    OP_AND3I   = 6'd28,
    OP_OR3     = 6'd29,
    OP_OR3I    = 6'd30,
    OP_XOR3    = 6'd31,
    OP_XOR3I   = 6'd32,
    OP_ASR3    = 6'd33,
    OP_SLEEP   = 6'd34,
    OP_RAND    = 6'd35,
    OP_LEA     = 6'd36,
    OP_PRINT   = 6'd37,
    OP_PRINTI  = 6'd38
  } opcode_e;

  typedef enum logic [2:0] {
    COND_EQ  = 3'd0,
    COND_NE  = 3'd1,
    COND_GT  = 3'd2,
    COND_LT  = 3'd3,
    COND_GE  = 3'd4,
    COND_GEU = 3'd5,
    COND_LTU = 3'd6,
    COND_LE  = 3'd7
  } cond_e;

  typedef enum logic [1:0] {
    PTR_PC = 2'd0,
    PTR_SP = 2'd1,
    PTR_A0 = 2'd2,
    PTR_A1 = 2'd3
  } ptr_e;

  typedef enum logic [1:0] {
    CFG_STACK_BASE = 2'd0,
    CFG_DATA_BASE  = 2'd1,
    CFG_VRAM_BASE  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ALU_ADD = 3'd0,
    ALU_SUB = 3'd1,
    ALU_AND = 3'd2,
    ALU_OR  = 3'd3,
    ALU_XOR = 3'd4,
    ALU_SHL = 3'd5,
    ALU_SHR = 3'd6,
    ALU_ASR = 3'd7
  } alu_op_e;

  typedef enum logic [1:0] {
    FLAG_KEEP = 2'd0,
    FLAG_ZNCV = 2'd1,
    FLAG_ZNC  = 2'd2
  } flag_upd_e;

  typedef struct packed {
    logic [5:0]         command;
    logic [RegIdxW-1:0] dest_reg;
    logic [RegIdxW-1:0] src_reg_a;
    logic [RegIdxW-1:0] src_reg_b;
    logic signed [63:0] constant;
    logic [2:0]         condition;
    logic [1:0]         pointer_sel;
    logic               shift_right;
    logic [5:0]         shift_amount;
    logic [7:0]         instr_length;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [63:0] written_value;
    logic [63:0] next_pc;
    logic [3:0]  flags;
    logic        halted;
  } out_t;

  typedef struct packed {
    logic [RegIdxW-1:0] a;
    logic [RegIdxW-1:0] b;
  } rd_addr_t;

  typedef struct packed {
    logic               gp_we;
    logic [RegIdxW-1:0] gp_waddr;
    logic [XLen-1:0]    gp_wdata;
    logic               ptr_we;
    logic [1:0]         ptr_sel;
    logic [XLen-1:0]    ptr_wdata;
    logic [XLen-1:0]    pc_next;
    logic [3:0]         flags_next;
    logic               halt_next;
  } upd_t;

  typedef struct packed {
    logic [XLen-1:0]               op_a;
    logic [XLen-1:0]               op_b;
    logic [XLen-1:0]               link;
    logic [NumPtrs-1:0][XLen-1:0]  ptrs;
    logic [3:0]                    flags;
    logic                          halt;
  } view_t;

  // Two-operand forms and shift read rd as the first source.
  function automatic rd_addr_t src_addrs(in_t w);
    rd_addr_t r;
    unique case (w.command)
      OP_ADD2, OP_ADD2I, OP_SUB2, OP_SUB2I, OP_SHIFT,
      OP_OR2, OP_OR2I, OP_AND2, OP_AND2I: begin
        r.a = w.dest_reg;
        r.b = w.src_reg_a;
      end
      default: begin
        r.a = w.src_reg_a;
        r.b = w.src_reg_b;
      end
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/rabu_ram.sv
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
`timescale 1ns / 1ps

module rabu_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hw/rtl/rabu_alu.sv
// 64-bit ALU of the register ALU branch unit: add, subtract, logic and shifts with C and V.
// Depends on rabu_pkg.
`timescale 1ns / 1ps

module rabu_alu (
  input  rabu_pkg::alu_op_e op_i,
  input  logic [63:0]       x_i,
  input  logic [63:0]       y_i,
  input  logic [5:0]        shamt_i,
  output logic [63:0]       res_o,
  output logic              c_o,
  output logic              v_o
);
  import rabu_pkg::*;

  logic [64:0]        sum;
  logic [64:0]        diff;
  logic [64:0]        shl;
  logic [64:0]        shr;
  logic signed [64:0] sra;

  // The extra bit catches the last bit shifted out; a zero shift leaves it clear.
  always_comb begin
    sum  = {1'b0, x_i} + {1'b0, y_i};
    diff = {1'b0, x_i} - {1'b0, y_i};
    shl  = {1'b0, x_i} << shamt_i;
    shr  = {x_i, 1'b0} >> shamt_i;
    sra  = $signed({x_i, 1'b0}) >>> shamt_i;
    res_o = sum[63:0];
    c_o   = 1'b0;
    v_o   = 1'b0;
    unique case (op_i)
      ALU_ADD: begin
        res_o = sum[63:0];
        c_o   = sum[64];
        v_o   = ~(x_i[63] ^ y_i[63]) & (x_i[63] ^ sum[63]);
      end
      ALU_SUB: begin
        res_o = diff[63:0];
        c_o   = diff[64];
        v_o   = (x_i[63] ^ y_i[63]) & (x_i[63] ^ diff[63]);
      end
      ALU_AND: res_o = x_i & y_i;
      ALU_OR:  res_o = x_i | y_i;
      ALU_XOR: res_o = x_i ^ y_i;
      ALU_SHL: begin
        res_o = shl[63:0];
        c_o   = shl[64];
      end
      ALU_SHR: begin
        res_o = shr[64:1];
        c_o   = shr[0];
      end
      ALU_ASR: begin
        res_o = sra[64:1];
        c_o   = sra[0];
      end
      default: res_o = sum[63:0];
    endcase
  end

endmodule

FILE: hw/rtl/rabu_state.sv
// Architectural state: register file RAM with forwarding, pointer counters, flags, halt.
// Depends on rabu_pkg and rabu_ram.
`timescale 1ns / 1ps

module rabu_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               exec_i,
  input  rabu_pkg::upd_t     upd_i,
  input  rabu_pkg::rd_addr_t rd_addr_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  output rabu_pkg::view_t    view_o
);
  import rabu_pkg::*;

  logic                         gp_we;
  logic [NumRegs-1:0]           gp_vld_q;
  logic                         vld_a_q;
  logic                         vld_b_q;
  logic                         fwd_a_q;
  logic                         fwd_b_q;
  logic [XLen-1:0]              fwd_data_q;
  logic [XLen-1:0]              rdata_a;
  logic [XLen-1:0]              rdata_b;
  logic [XLen-1:0]              link_q;
  logic [NumPtrs-1:0][XLen-1:0] ptr_q;
  logic [3:0]                   flags_q;
  logic                         halt_q;

  assign gp_we = exec_i & upd_i.gp_we;

  rabu_ram #(
    .Width (XLen),
    .Depth (NumRegs)
  ) u_gp_ram (
    .clk_i     (clk_i),
    .we_i      (gp_we),
    .waddr_i   (upd_i.gp_waddr),
    .wdata_i   (upd_i.gp_wdata),
    .raddr_a_i (rd_addr_i.a),
    .raddr_b_i (rd_addr_i.b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // A read issued in the same cycle as a write to that register takes the new value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gp_vld_q <= '0;
      vld_a_q  <= 1'b0;
      vld_b_q  <= 1'b0;
      fwd_a_q  <= 1'b0;
      fwd_b_q  <= 1'b0;
      link_q   <= '0;
    end else begin
      vld_a_q <= gp_vld_q[rd_addr_i.a];
      vld_b_q <= gp_vld_q[rd_addr_i.b];
      fwd_a_q <= gp_we && (upd_i.gp_waddr == rd_addr_i.a);
      fwd_b_q <= gp_we && (upd_i.gp_waddr == rd_addr_i.b);
      if (gp_we) begin
        gp_vld_q[upd_i.gp_waddr] <= 1'b1;
        if (upd_i.gp_waddr == LinkReg) begin
          link_q <= upd_i.gp_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= upd_i.gp_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      flags_q <= '0;
      halt_q  <= 1'b0;
    end else if (exec_i) begin
      ptr_q[PTR_PC] <= upd_i.pc_next;
      if (upd_i.ptr_we) begin
        ptr_q[upd_i.ptr_sel] <= upd_i.ptr_wdata;
      end
      flags_q <= upd_i.flags_next;
      halt_q  <= upd_i.halt_next;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_STACK_BASE: ptr_q[PTR_SP] <= cfg_data_i;
        CFG_DATA_BASE:  ptr_q[PTR_A0] <= cfg_data_i;
        CFG_VRAM_BASE:  ptr_q[PTR_A1] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    view_o.op_a  = fwd_a_q ? fwd_data_q : (vld_a_q ? rdata_a : '0);
    view_o.op_b  = fwd_b_q ? fwd_data_q : (vld_b_q ? rdata_b : '0);
    view_o.link  = link_q;
    view_o.ptrs  = ptr_q;
    view_o.flags = flags_q;
    view_o.halt  = halt_q;
  end

endmodule

FILE: hw/rtl/rabu_exec.sv
// Execute stage: decodes one instruction word and computes the state update and result word.
// Depends on rabu_pkg and rabu_alu.
`timescale 1ns / 1ps

module rabu_exec (
  input  rabu_pkg::in_t   word_i,
  input  rabu_pkg::view_t view_i,
  output rabu_pkg::upd_t  upd_o,
  output rabu_pkg::out_t  res_o
);
  import rabu_pkg::*;

  alu_op_e         alu_op;
  logic            use_imm;
  logic [XLen-1:0] alu_y;
  logic [XLen-1:0] alu_res;
  logic            alu_c;
  logic            alu_v;
  logic [XLen-1:0] pc;
  logic [XLen-1:0] pc_adv;
  logic [XLen-1:0] jmp_tgt;
  logic            cond_ok;
  logic            supported;
  logic            take;
  flag_upd_e       fcls;
  logic [3:0]      fl;

  assign fl      = view_i.flags;
  assign pc      = view_i.ptrs[PTR_PC];
  assign pc_adv  = pc + {56'd0, word_i.instr_length};
  assign jmp_tgt = pc_adv + word_i.constant;
  assign alu_y   = use_imm ? word_i.constant : view_i.op_b;

  always_comb begin
    unique case (cond_e'(word_i.condition))
      COND_EQ:  cond_ok = fl[FlagZ];
      COND_NE:  cond_ok = !fl[FlagZ];
      COND_GT:  cond_ok = !fl[FlagZ] && (fl[FlagN] == fl[FlagV]);
      COND_LT:  cond_ok = fl[FlagN] != fl[FlagV];
      COND_GE:  cond_ok = fl[FlagN] == fl[FlagV];
      COND_GEU: cond_ok = !fl[FlagC];
      COND_LTU: cond_ok = fl[FlagC];
      COND_LE:  cond_ok = fl[FlagZ] || (fl[FlagN] != fl[FlagV]);
      default:  cond_ok = 1'b0;
    endcase
  end

  always_comb begin
    alu_op  = ALU_ADD;
    use_imm = 1'b0;
    unique case (word_i.command)
      OP_ADD2, OP_ADD3:                      alu_op = ALU_ADD;
      OP_ADD2I, OP_ADD3I: begin
        alu_op  = ALU_ADD;
        use_imm = 1'b1;
      end
      OP_SUB2, OP_SUB3, OP_CMP:              alu_op = ALU_SUB;
      OP_SUB2I, OP_SUB3I, OP_CMPI: begin
        alu_op  = ALU_SUB;
        use_imm = 1'b1;
      end
      OP_AND2, OP_AND3:                      alu_op = ALU_AND;
      OP_AND2I, OP_AND3I: begin
        alu_op  = ALU_AND;
        use_imm = 1'b1;
      end
      OP_OR2, OP_OR3:                        alu_op = ALU_OR;
      OP_OR2I, OP_OR3I: begin
        alu_op  = ALU_OR;
        use_imm = 1'b1;
      end
      OP_XOR3:                               alu_op = ALU_XOR;
      OP_XOR3I: begin
        alu_op  = ALU_XOR;
        use_imm = 1'b1;
      end
      OP_SHIFT: alu_op = word_i.shift_right ? ALU_SHR : ALU_SHL;
      OP_ASR3:  alu_op = ALU_ASR;
      default:  alu_op = ALU_ADD;
    endcase
  end

  rabu_alu u_alu (
    .op_i    (alu_op),
    .x_i     (view_i.op_a),
    .y_i     (alu_y),
    .shamt_i (word_i.shift_amount),
    .res_o   (alu_res),
    .c_o     (alu_c),
    .v_o     (alu_v)
  );

  always_comb begin
    supported       = 1'b1;
    take            = 1'b0;
    fcls            = FLAG_KEEP;
    upd_o.gp_we     = 1'b0;
    upd_o.gp_waddr  = word_i.dest_reg;
    upd_o.gp_wdata  = alu_res;
    upd_o.ptr_we    = 1'b0;
    upd_o.ptr_sel   = word_i.pointer_sel;
    upd_o.ptr_wdata = view_i.op_a;
    upd_o.pc_next   = pc_adv;
    unique case (word_i.command)
      OP_ADD2, OP_ADD2I, OP_SUB2, OP_SUB2I,
      OP_ADD3, OP_ADD3I, OP_SUB3, OP_SUB3I: begin
        upd_o.gp_we = 1'b1;
        fcls        = FLAG_ZNCV;
      end
      OP_CMP, OP_CMPI: fcls = FLAG_ZNCV;
      OP_SHIFT, OP_ASR3, OP_OR2, OP_OR2I, OP_AND2, OP_AND2I,
      OP_AND3, OP_AND3I, OP_OR3, OP_OR3I, OP_XOR3, OP_XOR3I: begin
        upd_o.gp_we = 1'b1;
        fcls        = FLAG_ZNC;
      end
      OP_LET: begin
        upd_o.gp_we    = 1'b1;
        upd_o.gp_wdata = view_i.op_a;
      end
      OP_LETI: begin
        upd_o.gp_we    = 1'b1;
        upd_o.gp_wdata = word_i.constant;
      end
      OP_JUMP:   take = 1'b1;
      OP_JUMPIF: take = cond_ok;
      OP_CALL: begin
        upd_o.gp_we    = 1'b1;
        upd_o.gp_waddr = LinkReg;
        upd_o.gp_wdata = pc_adv;
        upd_o.pc_next  = word_i.constant;
      end
      OP_SETCTR: begin
        if (word_i.pointer_sel == PTR_PC) begin
          upd_o.pc_next = view_i.op_a;
        end else begin
          upd_o.ptr_we = 1'b1;
        end
      end
      OP_GETCTR: begin
        upd_o.gp_we    = 1'b1;
        upd_o.gp_wdata = (word_i.pointer_sel == PTR_PC) ? pc_adv
                                                         : view_i.ptrs[word_i.pointer_sel];
      end
      OP_RETURN: upd_o.pc_next = view_i.link;
      OP_LEA: begin
        upd_o.gp_we    = 1'b1;
        upd_o.gp_wdata = jmp_tgt;
      end
      default: begin
        supported     = 1'b0;
        upd_o.pc_next = pc;
      end
    endcase

    if (take) begin
      upd_o.pc_next = jmp_tgt;
    end
    upd_o.halt_next = view_i.halt || (take && (jmp_tgt == pc));

    unique case (fcls)
      FLAG_ZNCV: upd_o.flags_next = {alu_res == '0, alu_res[XLen-1], alu_c, alu_v};
      FLAG_ZNC:  upd_o.flags_next = {alu_res == '0, alu_res[XLen-1], alu_c, fl[FlagV]};
      default:   upd_o.flags_next = fl;
    endcase

    res_o.status        = !supported;
    res_o.written_value = upd_o.gp_we ? upd_o.gp_wdata : '0;
    res_o.next_pc       = upd_o.pc_next;
    res_o.flags         = upd_o.flags_next;
    res_o.halted        = upd_o.halt_next;
  end

endmodule

FILE: hw/rtl/register_alu_branch_unit.sv
// Top level of the register ALU branch unit: input and result registers around the execute stage.
// Depends on rabu_pkg, rabu_state and rabu_exec.
//
// The unit executes one decoded instruction word per accepted input and answers with exactly
// one result word. Both channels use valid and stall: a word moves at a rising edge where
// valid is high and stall is low. The configuration channel (valid and ready) writes the
// stack, data and video bases straight into the pointers SP, A0 and A1; index three is
// ignored. Write it only while no instruction is in flight.
// An accepted word is registered and reads the register file at the same edge; it executes
// as soon as the result register can take a word and then lands there. One word per cycle is
// sustained while the receiver does not stall; the execute path is combinational and updates
// the registers, pointers and flags before the next word uses them.
// When the receiver stalls, the result register holds its word and the input register can
// still take one more word; beyond that the input channel stalls.
// Reset clears the general registers, PC, SP, A0, A1, the flags and the halt mark, and empties
// both registers of the pipeline.
`timescale 1ns / 1ps

module register_alu_branch_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rabu_pkg::in_t  in_word_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rabu_pkg::out_t out_word_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [63:0]    cfg_data_i
);
  import rabu_pkg::*;

  logic     in_valid_q;
  logic     in_valid_d;
  in_t      in_q;
  logic     out_valid_q;
  logic     out_valid_d;
  out_t     out_q;
  logic     exec_en;
  logic     accept;
  rd_addr_t rd_addr;
  upd_t     upd;
  view_t    view;
  out_t     res;

  assign exec_en     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !exec_en;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = !in_valid_q;
  assign rd_addr     = accept ? src_addrs(in_word_i) : src_addrs(in_q);

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (exec_en) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (exec_en) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_word_i;
    end
    if (exec_en) begin
      out_q <= res;
    end
  end

  rabu_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exec_i      (exec_en),
    .upd_i       (upd),
    .rd_addr_i   (rd_addr),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .view_o      (view)
  );

  rabu_exec u_exec (
    .word_i (in_q),
    .view_i (view),
    .upd_o  (upd),
    .res_o  (res)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: hw/rtl/rabu_checker.sv
// Port-level checker of the register ALU branch unit and its bind to the top level.
// Depends on rabu_pkg and register_alu_branch_unit_defines.svh.
`timescale 1ns / 1ps
`include "register_alu_branch_unit_defines.svh"

module rabu_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rabu_pkg::out_t out_word_o
);
  import rabu_pkg::*;

  logic seen_halt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_halt_q <= 1'b0;
    end else if (out_valid_o && !out_stall_i && out_word_o.halted) begin
      seen_halt_q <= 1'b1;
    end
  end

  `RABU_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o),
    "stalled result word changed")
  `RABU_ASSERT_ALWAYS(a_no_stall_when_empty, clk_i,
    !out_valid_o |-> !in_stall_o,
    "input stalled while result register empty")
  `RABU_ASSERT(a_unsupported_no_write, clk_i, rst_ni,
    out_valid_o && out_word_o.status |-> out_word_o.written_value == '0,
    "unsupported word reports a written value")
  `RABU_ASSERT(a_halt_sticky, clk_i, rst_ni,
    out_valid_o && seen_halt_q |-> out_word_o.halted,
    "halt mark cleared after it was set")

endmodule

bind register_alu_branch_unit rabu_checker u_rabu_checker (.*);
